// ----- design/vfdg_pkg.sv -----
// Shared constants of the volume gradient block
package vfdg_pkg;

  // configuration channel
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z = 2'd2;

  // request opcodes
  localparam logic OP_VOXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

endpackage

// ----- design/vfdg_voxel_if.sv -----
// Voxel request channel
interface vfdg_voxel_if #(
  parameter int VALUE_WIDTH = 16
);
  logic                          valid;
  logic                          ready;
  logic                          op;
  logic signed [VALUE_WIDTH-1:0] value;
  logic                          value_invalid;
  logic                          in_mask;

  modport source (output valid, op, value, value_invalid, in_mask, input ready);
  modport sink   (input valid, op, value, value_invalid, in_mask, output ready);
endinterface

// ----- design/vfdg_result_if.sv -----
// Gradient result channel
interface vfdg_result_if #(
  parameter int VALUE_WIDTH = 16
);
  logic                        valid;
  logic                        ready;
  logic signed [VALUE_WIDTH:0] grad_x;
  logic signed [VALUE_WIDTH:0] grad_y;
  logic signed [VALUE_WIDTH:0] grad_z;
  logic                        write_enable;
  logic                        last_voxel;

  modport source (output valid, grad_x, grad_y, grad_z, write_enable, last_voxel,
                  input ready);
  modport sink   (input valid, grad_x, grad_y, grad_z, write_enable, last_voxel,
                  output ready);
endinterface

// ----- design/vfdg_cfg_if.sv -----
// Register write channel
interface vfdg_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [vfdg_pkg::CFG_IDX_W-1:0]    index;
  logic [vfdg_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- design/volume_forward_difference_gradient.sv -----
// A result passes through the read stage, then the output register; one request
//   is taken every cycle while the result channel does not stall.
// Plane halves live in two single-write, dual-read RAMs; each request costs
//   at most one write and up to two reads per RAM, so the rate is one per cycle unless the output stalls.
// Reset clears counters, sizes (2 x 2 x 1) and handshake state; the plane
//   RAMs are not cleared and need no sweep.
module volume_forward_difference_gradient #(
  parameter int MAX_NX      = 256,
  parameter int MAX_NY      = 256,
  parameter int MAX_NZ      = 256,
  parameter int VALUE_WIDTH = 16
) (
  input  logic                clk,
  input  logic                rst,
  vfdg_voxel_if.sink          vox,
  vfdg_result_if.source       res,
  vfdg_cfg_if.sink            cfg
);

  localparam int XW    = $clog2(MAX_NX);
  localparam int YW    = $clog2(MAX_NY);
  localparam int ZW    = (MAX_NZ > 1) ? $clog2(MAX_NZ) : 1;
  localparam int SXW   = $clog2(MAX_NX + 1);
  localparam int SYW   = $clog2(MAX_NY + 1);
  localparam int SZW   = $clog2(MAX_NZ + 1);
  localparam int PLANE = MAX_NX * MAX_NY;
  localparam int AW    = $clog2(PLANE);
  localparam int EW    = VALUE_WIDTH + 2;
  localparam int GW    = VALUE_WIDTH + 1;

  typedef logic [EW-1:0] entry_t;
  typedef logic [AW-1:0] addr_t;

  // control carried from the read cycle to the combine cycle
  typedef struct packed {
    logic x_last;
    logic y_last;
    logic z_on;
    logic z_back;
    logic next_half;
    logic c_half;
    logic last;
  } stage_t;

  // slot of (x, y) within one plane half
  function automatic addr_t slot(input logic [XW-1:0] x, input logic [YW-1:0] y);
    slot = AW'(y) * AW'(MAX_NX) + AW'(x);
  endfunction

  // a minus b, zero when either side is not a number
  function automatic logic [GW-1:0] diff(input entry_t a, input entry_t b);
    logic signed [GW-1:0] av;
    logic signed [GW-1:0] bv;
    av = GW'($signed(a[VALUE_WIDTH-1:0]));
    bv = GW'($signed(b[VALUE_WIDTH-1:0]));
    if (a[VALUE_WIDTH] || b[VALUE_WIDTH]) diff = '0;
    else diff = av - bv;
  endfunction

  function automatic int clamp(input logic [vfdg_pkg::CFG_DATA_W-1:0] v,
                               input int lo, input int hi);
    int iv;
    iv = int'(v);
    if (iv < lo) clamp = lo;
    else if (iv > hi) clamp = hi;
    else clamp = iv;
  endfunction

  logic [SXW-1:0] size_x;
  logic [SYW-1:0] size_y;
  logic [SZW-1:0] size_z;

  logic [XW-1:0] in_x;
  logic [YW-1:0] in_y;
  logic [ZW-1:0] in_z;
  logic          in_full;
  logic [XW-1:0] ox;
  logic [YW-1:0] oy;
  logic [ZW-1:0] oz;

  logic   s1_valid;
  stage_t s1;
  entry_t s1_zn;
  entry_t cur;
  entry_t prev;

  entry_t mem0 [PLANE];
  entry_t mem1 [PLANE];
  entry_t rd0a, rd0b, rd1a, rd1b;

  logic   s1_move;
  logic   in_acc;
  logic   cfg_hit;
  logic   wr_en;
  logic   fire;
  addr_t  wr_addr;
  entry_t wr_entry;
  logic   in_x_end, in_y_end, in_z_end;
  logic   x_last, y_last, z_last, z_on, z_back;
  logic   next_half;
  addr_t  ra_addr, y_addr, z_addr, rb_addr0, rb_addr1;
  logic   ra_en0, ra_en1, rb_en0, rb_en1;
  logic   [XW-1:0] nx;
  logic   [YW-1:0] ny;

  // handshakes
  assign s1_move   = s1_valid && (!res.valid || res.ready);
  assign vox.ready = !s1_valid || s1_move;
  assign cfg.ready = 1'b1;
  assign in_acc    = vox.valid && vox.ready;

  always_comb begin
    case (cfg.index)
      vfdg_pkg::REG_SIZE_X, vfdg_pkg::REG_SIZE_Y, vfdg_pkg::REG_SIZE_Z: cfg_hit = cfg.valid;
      default: cfg_hit = 1'b0;
    endcase
  end

  // input side: voxel write
  assign wr_en    = in_acc && (vox.op == vfdg_pkg::OP_VOXEL) && !in_full;
  assign wr_addr  = slot(in_x, in_y);
  assign wr_entry = {vox.in_mask, vox.value_invalid, vox.value};
  assign in_x_end = (SXW'(in_x) + SXW'(1)) == size_x;
  assign in_y_end = (SYW'(in_y) + SYW'(1)) == size_y;
  assign in_z_end = (SZW'(in_z) + SZW'(1)) == size_z;

  // a result is due: streaming from plane 1 on, or a drain tick when full
  assign fire = in_acc &&
                (((vox.op == vfdg_pkg::OP_VOXEL) && !in_full && (in_z != '0)) ||
                 ((vox.op == vfdg_pkg::OP_DRAIN) && in_full));

  // output position and neighbour addresses
  assign x_last    = (SXW'(ox) + SXW'(1)) == size_x;
  assign y_last    = (SYW'(oy) + SYW'(1)) == size_y;
  assign z_last    = (SZW'(oz) + SZW'(1)) == size_z;
  assign z_on      = size_z != SZW'(1);
  assign z_back    = z_on && z_last;
  assign next_half = (x_last && y_last) ? ~oz[0] : oz[0];
  assign nx        = x_last ? '0 : ox + 1'b1;
  assign ny        = x_last ? (y_last ? '0 : oy + 1'b1) : oy;
  assign ra_addr   = slot(nx, ny);
  assign y_addr    = y_last ? slot(ox, oy - 1'b1) : slot(ox, oy + 1'b1);
  assign z_addr    = slot(ox, oy);
  assign rb_addr0  = oz[0] ? z_addr : y_addr;
  assign rb_addr1  = oz[0] ? y_addr : z_addr;
  assign ra_en0    = fire && !next_half;
  assign ra_en1    = fire && next_half;
  assign rb_en0    = fire && (!oz[0] || z_back);
  assign rb_en1    = fire && (oz[0] || z_back);

  // even-plane RAM
  always_ff @(posedge clk) begin
    if (wr_en && !in_z[0]) mem0[wr_addr] <= wr_entry;
    if (ra_en0) rd0a <= mem0[ra_addr];
    if (rb_en0) rd0b <= mem0[rb_addr0];
  end

  // odd-plane RAM
  always_ff @(posedge clk) begin
    if (wr_en && in_z[0]) mem1[wr_addr] <= wr_entry;
    if (ra_en1) rd1a <= mem1[ra_addr];
    if (rb_en1) rd1b <= mem1[rb_addr1];
  end

  // sizes, counters and pass control
  always_ff @(posedge clk) begin
    if (rst) begin
      size_x   <= SXW'(2);
      size_y   <= SYW'(2);
      size_z   <= SZW'(1);
      in_x     <= '0;
      in_y     <= '0;
      in_z     <= '0;
      in_full  <= 1'b0;
      ox       <= '0;
      oy       <= '0;
      oz       <= '0;
    end else if (cfg_hit) begin
      unique case (cfg.index)
        vfdg_pkg::REG_SIZE_X: size_x <= SXW'(clamp(cfg.data, 2, MAX_NX));
        vfdg_pkg::REG_SIZE_Y: size_y <= SYW'(clamp(cfg.data, 2, MAX_NY));
        vfdg_pkg::REG_SIZE_Z: size_z <= SZW'(clamp(cfg.data, 1, MAX_NZ));
        default: ;
      endcase
      in_x    <= '0;
      in_y    <= '0;
      in_z    <= '0;
      in_full <= 1'b0;
      ox      <= '0;
      oy      <= '0;
      oz      <= '0;
    end else begin
      if (wr_en) begin
        if (!in_x_end) begin
          in_x <= in_x + 1'b1;
        end else begin
          in_x <= '0;
          if (!in_y_end) begin
            in_y <= in_y + 1'b1;
          end else begin
            in_y <= '0;
            if (!in_z_end) begin
              in_z <= in_z + 1'b1;
            end else begin
              in_z    <= '0;
              in_full <= 1'b1;
            end
          end
        end
      end
      if (fire) begin
        ox <= nx;
        oy <= ny;
        if (x_last && y_last) oz <= z_last ? '0 : oz + 1'b1;
        // final result of the pass: back to an empty volume
        if (x_last && y_last && z_last) in_full <= 1'b0;
      end
    end
  end

  // read stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_acc) begin
      s1_valid <= fire;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      s1.x_last    <= x_last;
      s1.y_last    <= y_last;
      s1.z_on      <= z_on;
      s1.z_back    <= z_back;
      s1.next_half <= next_half;
      s1.c_half    <= oz[0];
      s1.last      <= x_last && y_last && z_last;
      s1_zn        <= wr_entry;
    end
  end

  // centre window along x; the first voxel of a pass seeds the centre
  always_ff @(posedge clk) begin
    if (s1_move) begin
      prev <= cur;
      cur  <= s1.next_half ? rd1a : rd0a;
    end
    if (wr_en && (in_x == '0) && (in_y == '0) && (in_z == '0)) cur <= wr_entry;
  end

  // combine neighbours
  entry_t          nextc, ynb, znb;
  logic   [GW-1:0] gx, gy, gz;
  logic            we;

  always_comb begin
    nextc = s1.next_half ? rd1a : rd0a;
    ynb   = s1.c_half ? rd1b : rd0b;
    znb   = s1.c_half ? rd0b : rd1b;
    we    = cur[EW-1];
    gx    = s1.x_last ? diff(cur, prev) : diff(nextc, cur);
    gy    = s1.y_last ? diff(cur, ynb) : diff(ynb, cur);
    if (!s1.z_on) gz = '0;
    else if (s1.z_back) gz = diff(cur, znb);
    else gz = diff(s1_zn, cur);
    if (!we) begin
      gx = '0;
      gy = '0;
      gz = '0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (s1_move) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      res.grad_x       <= gx;
      res.grad_y       <= gy;
      res.grad_z       <= gz;
      res.write_enable <= we;
      res.last_voxel   <= s1.last;
    end
  end

  // no RAM reads a slot that is written in the same cycle
  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    !(wr_en && ((!in_z[0] && ((ra_en0 && wr_addr == ra_addr) ||
                              (rb_en0 && wr_addr == rb_addr0))) ||
                ( in_z[0] && ((ra_en1 && wr_addr == ra_addr) ||
                              (rb_en1 && wr_addr == rb_addr1))))))
    else $error("RAM read and write hit the same slot");

  // a pass starts with the result position at the origin
  a_pass_start: assert property (@(posedge clk) disable iff (rst)
    wr_en && (in_x == '0) && (in_y == '0) && (in_z == '0)
      |-> (ox == '0) && (oy == '0) && (oz == '0))
    else $error("result position not at origin at start of pass");

  // a stalled read stage keeps its control
  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_move |=> s1_valid && $stable(s1))
    else $error("read stage lost its contents under back-pressure");

  // the last result of a pass empties the volume
  a_last_restart: assert property (@(posedge clk) disable iff (rst)
    fire && x_last && y_last && z_last && !cfg_hit |=> !in_full && (ox == '0))
    else $error("pass did not restart after its final result");

endmodule
